// File: hdl/i2p_pkg.sv
// Shared types, character codes and precedence functions for the
// infix-to-postfix converter. No dependencies.

package i2p_pkg;

	// Operator stack depth used by default
	localparam int unsigned STACK_DEPTH_DEF = 32;
	localparam int unsigned SYM_W           = 8;

	// Operator characters
	localparam logic [SYM_W-1:0] CH_ADD   = 8'h2B; // '+'
	localparam logic [SYM_W-1:0] CH_SUB   = 8'h2D; // '-'
	localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A; // '*'
	localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F; // '/'
	localparam logic [SYM_W-1:0] CH_POW   = 8'h5E; // '^'
	localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28; // '('
	localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29; // ')'

	// Error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_CLOSE    = 2'd2;
	localparam logic [1:0] ERR_OPEN     = 2'd3;

	// Sequencer states
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_OPER   = 6'b000010,
		ST_CLOSE  = 6'b000100,
		ST_FLUSH  = 6'b001000,
		ST_REFILL = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	// One postfix result before end-of-input marking
	typedef struct packed {
		logic             has_symbol;
		logic [SYM_W-1:0] out_symbol;
		logic [1:0]       error;
	} res_t;

	// Requests from the sequencer to the result queue
	typedef struct packed {
		logic emit;   // push one result
		res_t res;
		logic close;  // input finished: mark last result
		logic expr;   // input was the expression's last character
	} q_req_t;

	// Queue status back to the sequencer
	typedef struct packed {
		logic emit_ok;
		logic close_ok;
	} q_stat_t;

	function automatic logic is_oper(input logic [SYM_W-1:0] c);
		return (c == CH_ADD) || (c == CH_SUB) || (c == CH_MUL) || (c == CH_DIV) ||
			(c == CH_POW) || (c == CH_OPEN) || (c == CH_CLOSE);
	endfunction

	// Precedence of a symbol sitting on the stack
	function automatic logic [2:0] in_prec(input logic [SYM_W-1:0] c);
		logic [2:0] p;
		p = 3'd0;
		if ((c == CH_ADD) || (c == CH_SUB)) p = 3'd2;
		else if ((c == CH_MUL) || (c == CH_DIV)) p = 3'd4;
		else if (c == CH_POW) p = 3'd5;
		return p;
	endfunction

	// Precedence of an arriving symbol
	function automatic logic [2:0] out_prec(input logic [SYM_W-1:0] c);
		logic [2:0] p;
		p = 3'd0;
		if ((c == CH_ADD) || (c == CH_SUB)) p = 3'd1;
		else if ((c == CH_MUL) || (c == CH_DIV)) p = 3'd3;
		else if (c == CH_POW) p = 3'd6;
		else if (c == CH_OPEN) p = 3'd7;
		return p;
	endfunction

endpackage

// File: hdl/i2p_stack_ram.sv
// Operator stack storage: one write port, one read port, registered read.
// Depends on i2p_pkg for the symbol width.

module i2p_stack_ram import i2p_pkg::*; #(
	parameter int unsigned DEPTH = STACK_DEPTH_DEF,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [SYM_W-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [SYM_W-1:0] rd_data
);

	logic [SYM_W-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// File: hdl/i2p_result_queue.sv
// Result hold stage and output register; marks the last result of an input.
// Depends on i2p_pkg for the request and status structs.

module i2p_result_queue import i2p_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  q_req_t           req,
	output q_stat_t          stat,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             has_symbol,
	output logic [SYM_W-1:0] out_symbol,
	output logic             run_last,
	output logic             expr_done,
	output logic [1:0]       error
);

	logic       pend_vld_q;
	res_t       pend_q;
	logic       out_vld_q;
	res_t       out_res_q;
	logic       out_last_q;
	logic       out_done_q;
	logic       out_free;
	logic       load_out;

	assign out_free      = !out_vld_q || out_ready;
	assign stat.emit_ok  = !pend_vld_q || out_free;
	assign stat.close_ok = out_free;
	assign load_out      = (req.emit && pend_vld_q) ||
		(req.close && (pend_vld_q || req.expr));

	// Control: hold one result back until its successor or the end of input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (req.emit) begin
				pend_vld_q <= 1'b1;
			end else if (req.close) begin
				pend_vld_q <= 1'b0;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload: advance hold stage into the output register
	always_ff @(posedge clk) begin
		if (req.emit) begin
			pend_q <= req.res;
			if (pend_vld_q) begin
				out_res_q  <= pend_q;
				out_last_q <= 1'b0;
				out_done_q <= 1'b0;
			end
		end else if (req.close) begin
			if (pend_vld_q) begin
				out_res_q <= pend_q;
			end else begin
				out_res_q <= '{has_symbol: 1'b0, out_symbol: '0, error: ERR_NONE};
			end
			out_last_q <= 1'b1;
			out_done_q <= req.expr;
		end
	end

	assign out_valid  = out_vld_q;
	assign has_symbol = out_res_q.has_symbol;
	assign out_symbol = out_res_q.out_symbol;
	assign error      = out_res_q.error;
	assign run_last   = out_last_q;
	assign expr_done  = out_done_q;

endmodule

// File: hdl/infix_to_postfix_converter_unit.sv
// Top level of the shunting-yard infix-to-postfix converter.
// Depends on i2p_pkg, i2p_stack_ram and i2p_result_queue.
//
// Usage: one infix character enters per request on the input channel
// (symbol, final_symbol). Operands pass straight to the output; operators
// are held on a stack in a synchronous RAM and leave in postfix order.
// Each output request carries one result; run_last marks the last result of
// an input and expr_done the last result of the final input. A non-final
// input that causes no result (a pushed operator) gives no output request.
// Steps: an operand or an open parenthesis is handled on acceptance; any
// other operator first passes through an operator or close state. Every
// popped stack entry, a discarded open parenthesis included, takes a pop
// and then a reload of the new top from the RAM read port. A close
// parenthesis that finds its match discards it without a result. A final
// input then pops the whole stack the same way; a done state closes each
// input. An operand's result enters the hold stage on acceptance.
// Reset empties the stack and drops all pending results; stack contents
// need no clearing. When the receiver stalls, the output register holds,
// one more result waits in a hold stage, and then the sequencer stops.

module infix_to_postfix_converter_unit import i2p_pkg::*; #(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [SYM_W-1:0] symbol,
	input  logic             final_symbol,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             has_symbol,
	output logic [SYM_W-1:0] out_symbol,
	output logic             run_last,
	output logic             expr_done,
	output logic [1:0]       error
);

	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	state_t           st_q, st_d;
	state_t           ret_q, ret_d;
	logic [CW-1:0]    count_q;
	logic [SYM_W-1:0] top_q;
	logic [SYM_W-1:0] sym_q;
	logic             fin_q;
	logic [SYM_W-1:0] rd_data;
	logic [CW-1:0]    below_top;
	logic             full;
	logic             empty;
	logic             push_en;
	logic [SYM_W-1:0] push_sym;
	logic             pop_en;
	logic             accept;
	state_t           after_in;
	state_t           after_op;
	q_req_t           req;
	q_stat_t          stat;

	assign full      = (count_q == CW'(STACK_DEPTH));
	assign empty     = (count_q == '0);
	assign below_top = count_q - CW'(2);
	assign in_ready  = (st_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign after_in  = final_symbol ? ST_FLUSH : ST_DONE;
	assign after_op  = fin_q ? ST_FLUSH : ST_DONE;

	i2p_stack_ram #(
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (push_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (push_sym),
		.rd_addr (below_top[AW-1:0]),
		.rd_data (rd_data)
	);

	i2p_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.has_symbol (has_symbol),
		.out_symbol (out_symbol),
		.run_last   (run_last),
		.expr_done  (expr_done),
		.error      (error)
	);

	// Sequencer: decide pops, pushes and results for the current input
	always_comb begin
		st_d     = st_q;
		ret_d    = ret_q;
		push_en  = 1'b0;
		push_sym = sym_q;
		pop_en   = 1'b0;
		req      = '0;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!is_oper(symbol)) begin
						req.emit = 1'b1;
						req.res  = '{has_symbol: 1'b1, out_symbol: symbol, error: ERR_NONE};
						st_d     = after_in;
					end else if (symbol == CH_OPEN) begin
						if (full) begin
							req.emit = 1'b1;
							req.res  = '{has_symbol: 1'b0, out_symbol: '0, error: ERR_OVERFLOW};
						end else begin
							push_en  = 1'b1;
							push_sym = symbol;
						end
						st_d = after_in;
					end else if (symbol == CH_CLOSE) begin
						st_d = ST_CLOSE;
					end else begin
						st_d = ST_OPER;
					end
				end
			end
			ST_OPER: begin
				if (!empty && (out_prec(sym_q) < in_prec(top_q))) begin
					if (stat.emit_ok) begin
						req.emit = 1'b1;
						req.res  = '{has_symbol: 1'b1, out_symbol: top_q, error: ERR_NONE};
						pop_en   = 1'b1;
						ret_d    = ST_OPER;
						st_d     = ST_REFILL;
					end
				end else if (full) begin
					if (stat.emit_ok) begin
						req.emit = 1'b1;
						req.res  = '{has_symbol: 1'b0, out_symbol: '0, error: ERR_OVERFLOW};
						st_d     = after_op;
					end
				end else begin
					push_en = 1'b1;
					st_d    = after_op;
				end
			end
			ST_CLOSE: begin
				if (empty) begin
					if (stat.emit_ok) begin
						req.emit = 1'b1;
						req.res  = '{has_symbol: 1'b0, out_symbol: '0, error: ERR_CLOSE};
						st_d     = after_op;
					end
				end else if (top_q == CH_OPEN) begin
					// drop the matching open parenthesis
					pop_en = 1'b1;
					ret_d  = after_op;
					st_d   = ST_REFILL;
				end else if (stat.emit_ok) begin
					req.emit = 1'b1;
					req.res  = '{has_symbol: 1'b1, out_symbol: top_q, error: ERR_NONE};
					pop_en   = 1'b1;
					ret_d    = ST_CLOSE;
					st_d     = ST_REFILL;
				end
			end
			ST_FLUSH: begin
				if (empty) begin
					st_d = ST_DONE;
				end else if (stat.emit_ok) begin
					req.emit = 1'b1;
					if (top_q == CH_OPEN) begin
						req.res = '{has_symbol: 1'b0, out_symbol: '0, error: ERR_OPEN};
					end else begin
						req.res = '{has_symbol: 1'b1, out_symbol: top_q, error: ERR_NONE};
					end
					pop_en = 1'b1;
					ret_d  = ST_FLUSH;
					st_d   = ST_REFILL;
				end
			end
			ST_REFILL: begin
				st_d = ret_q;
			end
			ST_DONE: begin
				if (stat.close_ok) begin
					req.close = 1'b1;
					req.expr  = fin_q;
					st_d      = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: state and stack count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			ret_q   <= ST_IDLE;
			count_q <= '0;
		end else begin
			st_q  <= st_d;
			ret_q <= ret_d;
			if (push_en) begin
				count_q <= count_q + CW'(1);
			end else if (pop_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Payload: latch request, keep top of stack next to the RAM
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q <= symbol;
			fin_q <= final_symbol;
		end
		if (push_en) begin
			top_q <= push_sym;
		end else if (st_q == ST_REFILL) begin
			top_q <= rd_data;
		end
	end

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expr_done |-> run_last)
		else $error("expression end not marked as last result");

	a_error_no_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error != ERR_NONE) |-> !has_symbol && (out_symbol == '0))
		else $error("error result carries a symbol");

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_en && pop_en) && !(push_en && full))
		else $error("illegal stack access");

	a_refill_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop_en |=> (st_q == ST_REFILL))
		else $error("pop not followed by top reload");

endmodule
